FILE: rtl/srr_pkg.sv
package srr_pkg;

  // Store depth and beam count limit.
  localparam int RAY_DEPTH  = 1024;
  localparam int BEAM_LIMIT = 1024;

  // Field widths.
  localparam int IDX_W      = 10;
  localparam int RANGE_W    = 16;
  localparam int CNT_W      = 11;
  localparam int RAY_AW     = $clog2(RAY_DEPTH);
  localparam int NUM_W      = 2 * IDX_W;
  localparam int ACC_W      = IDX_W + RANGE_W;
  localparam int MEM_W      = RANGE_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  // Divider step counter: two quotient bits per step.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] DIV_LAST_IDX = STEP_W'(IDX_W / 2 - 1);
  localparam logic [STEP_W-1:0] DIV_LAST_ACC = STEP_W'(RANGE_W / 2 - 1);

  // Item kinds.
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_COMPUTE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RAY_TOTAL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BEAM_TOTAL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_CEIL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_LIMIT  = 3'd4;

  // Configuration reset values.
  localparam logic [CNT_W-1:0]   RST_RAY_TOTAL    = 11'd181;
  localparam logic [CNT_W-1:0]   RST_BEAM_TOTAL   = 11'd181;
  localparam logic [RANGE_W-1:0] RST_RANGE_CEIL   = 16'd8000;
  localparam logic [RANGE_W-1:0] RST_RANGE_OFFSET = 16'd0;
  localparam logic [RANGE_W-1:0] RST_CLOSE_LIMIT  = 16'd100;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_ray;
    logic take_beam;
    logic div_load_idx;
    logic div_load_acc;
    logic div_step;
    logic rd_en;
    logic rd_sel_b;
    logic cap_quot;
    logic cap_ra;
    logic cap_rb;
    logic cap_close;
    logic out_load;
  } srr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic index_bad;
    logic close;
  } srr_sts_t;

endpackage

FILE: rtl/srr_ram.sv
module srr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/srr_ctrl.sv
module srr_ctrl import srr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_valid,
  input  logic     s_func,
  output logic     s_ready,
  input  logic     m_ready,
  output logic     m_valid,
  input  srr_sts_t sts,
  output srr_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_DIV1 = 4'd2;
  localparam logic [3:0] S_RDA  = 4'd3;
  localparam logic [3:0] S_RDB  = 4'd4;
  localparam logic [3:0] S_MULA = 4'd5;
  localparam logic [3:0] S_MULB = 4'd6;
  localparam logic [3:0] S_DIV2 = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]        state;
  logic [3:0]        state_next;
  logic [STEP_W-1:0] cnt;
  logic [STEP_W-1:0] cnt_next;

  assign s_ready = (state == S_IDLE);

  // Sequencer for one item.
  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_IDLE: begin
        if (s_valid) begin
          if (s_func == FUNC_COMPUTE) begin
            cmd.take_beam = 1'b1;
            state_next    = S_PREP;
          end else begin
            cmd.wr_ray = 1'b1;
          end
        end
      end
      S_PREP: begin
        if (sts.index_bad) begin
          state_next = S_FIN;
        end else begin
          cmd.div_load_idx = 1'b1;
          cnt_next         = '0;
          state_next       = S_DIV1;
        end
      end
      S_DIV1: begin
        cmd.div_step = 1'b1;
        if (cnt == DIV_LAST_IDX) begin
          state_next = S_RDA;
        end else begin
          cnt_next = cnt + STEP_W'(1);
        end
      end
      S_RDA: begin
        cmd.rd_en    = 1'b1;
        cmd.cap_quot = 1'b1;
        state_next   = S_RDB;
      end
      S_RDB: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sel_b = 1'b1;
        cmd.cap_ra   = 1'b1;
        state_next   = S_MULA;
      end
      S_MULA: begin
        cmd.cap_rb = 1'b1;
        state_next = S_MULB;
      end
      S_MULB: begin
        cmd.cap_close = 1'b1;
        if (sts.close) begin
          cmd.div_load_acc = 1'b1;
          cnt_next         = '0;
          state_next       = S_DIV2;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DIV2: begin
        cmd.div_step = 1'b1;
        if (cnt == DIV_LAST_ACC) begin
          state_next = S_FIN;
        end else begin
          cnt_next = cnt + STEP_W'(1);
        end
      end
      S_FIN: begin
        if (!m_valid || m_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, step counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.out_load) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  // A load item never leaves the idle state.
  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (s_valid && s_ready && s_func == FUNC_LOAD) |=> (state == S_IDLE))
    else $error("load item left the idle state");

  // A finished result with a free output register is shown next cycle.
  a_fin_shows_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !m_valid) |=> (m_valid && state == S_IDLE))
    else $error("finished result not presented");

endmodule

FILE: rtl/srr_datapath.sv
module srr_datapath import srr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [IDX_W-1:0]       in_index,
  input  logic [RANGE_W-1:0]     in_range,
  input  logic                   in_retro,
  input  srr_cmd_t               cmd,
  output srr_sts_t               sts,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_error
);

  // Configuration registers.
  logic [CNT_W-1:0]   ray_total;
  logic [CNT_W-1:0]   beam_total;
  logic [RANGE_W-1:0] range_ceil;
  logic [RANGE_W-1:0] range_offset;
  logic [RANGE_W-1:0] close_limit;

  // Effective counts.
  logic [CNT_W-1:0] rays_eff;
  logic [CNT_W-1:0] beams_eff;
  logic [IDX_W-1:0] rays_m1;
  logic [IDX_W-1:0] den;

  // Item registers.
  logic [IDX_W-1:0]   idx_reg;
  logic [NUM_W-1:0]   num_reg;
  logic               err_reg;
  logic [RAY_AW-1:0]  ja_reg;
  logic [RAY_AW-1:0]  jb_reg;
  logic [IDX_W-1:0]   rem_reg;
  logic [RANGE_W-1:0] ra;
  logic [RANGE_W-1:0] rb;
  logic               ra_retro;
  logic               rb_retro;
  logic [ACC_W-1:0]   prod_a;
  logic               close_reg;

  // Divider registers.
  logic [IDX_W-1:0]   div_p;
  logic [RANGE_W-1:0] div_lo;
  logic [IDX_W:0]     s1;
  logic [IDX_W:0]     s2;

  // Store ports.
  logic               wr_en;
  logic [RAY_AW-1:0]  rd_addr;
  logic [MEM_W-1:0]   rd_data;
  logic [RANGE_W-1:0] rd_range_clip;

  // Combinational helpers.
  logic [CNT_W-1:0]   ja_ext;
  logic [CNT_W-1:0]   ja_inc;
  logic [RAY_AW-1:0]  jb_val;
  logic [ACC_W-1:0]   acc;
  logic [RANGE_W-1:0] diff;
  logic [RANGE_W-1:0] r_sel;
  logic [RANGE_W:0]   r_sum;
  logic [RANGE_W-1:0] r_sat;

  // Output payload.
  logic [IDX_W-1:0]   out_index;
  logic [IDX_W-1:0]   out_slot;
  logic [RANGE_W-1:0] out_range;
  logic               out_int;

  // One restoring division bit: returns the quotient bit over the new remainder.
  function automatic logic [IDX_W:0] div_bit(input logic [IDX_W-1:0] p, input logic b,
                                             input logic [IDX_W-1:0] d);
    logic [IDX_W:0] t;
    logic [IDX_W:0] sub;
    t   = {p, b};
    sub = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      div_bit = {1'b1, sub[IDX_W-1:0]};
    end else begin
      div_bit = {1'b0, t[IDX_W-1:0]};
    end
  endfunction

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      ray_total    <= RST_RAY_TOTAL;
      beam_total   <= RST_BEAM_TOTAL;
      range_ceil   <= RST_RANGE_CEIL;
      range_offset <= RST_RANGE_OFFSET;
      close_limit  <= RST_CLOSE_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RAY_TOTAL:    ray_total    <= cfg_data[CNT_W-1:0];
        REG_BEAM_TOTAL:   beam_total   <= cfg_data[CNT_W-1:0];
        REG_RANGE_CEIL:   range_ceil   <= cfg_data;
        REG_RANGE_OFFSET: range_offset <= cfg_data;
        REG_CLOSE_LIMIT:  close_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Counts limited to the supported span.
  always_comb begin
    if (ray_total < CNT_W'(2)) begin
      rays_eff = CNT_W'(2);
    end else if (ray_total > CNT_W'(RAY_DEPTH)) begin
      rays_eff = CNT_W'(RAY_DEPTH);
    end else begin
      rays_eff = ray_total;
    end
    if (beam_total < CNT_W'(2)) begin
      beams_eff = CNT_W'(2);
    end else if (beam_total > CNT_W'(BEAM_LIMIT)) begin
      beams_eff = CNT_W'(BEAM_LIMIT);
    end else begin
      beams_eff = beam_total;
    end
  end

  assign rays_m1 = IDX_W'(rays_eff - CNT_W'(1));
  assign den     = IDX_W'(beams_eff - CNT_W'(1));

  // Ray store: range in the low bits, retro flag on top.
  assign wr_en   = cmd.wr_ray && ({1'b0, in_index} < CNT_W'(RAY_DEPTH));
  assign rd_addr = cmd.rd_sel_b ? jb_reg : div_lo[RAY_AW-1:0];

  srr_ram #(
    .WIDTH (MEM_W),
    .DEPTH (RAY_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_index[RAY_AW-1:0]),
    .wr_data ({in_retro, in_range}),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_range_clip = (rd_data[RANGE_W-1:0] > range_ceil) ? range_ceil
                                                              : rd_data[RANGE_W-1:0];

  // Divider: two quotient bits shift into the low word per step.
  assign s1 = div_bit(div_p, div_lo[RANGE_W-1], den);
  assign s2 = div_bit(s1[IDX_W-1:0], div_lo[RANGE_W-2], den);

  // Interpolation sum and neighbor distance.
  assign acc  = prod_a + ACC_W'(rem_reg) * ACC_W'(rb);
  assign diff = (ra >= rb) ? (ra - rb) : (rb - ra);

  // Upper neighbor, held inside the ray count.
  assign ja_ext = {{(CNT_W-RAY_AW){1'b0}}, div_lo[RAY_AW-1:0]};
  assign ja_inc = ja_ext + CNT_W'(1);
  assign jb_val = (ja_inc < rays_eff) ? ja_inc[RAY_AW-1:0] : rays_m1[RAY_AW-1:0];

  assign sts.index_bad = err_reg;
  assign sts.close     = (diff < close_limit);

  // Item datapath registers.
  always_ff @(posedge clk) begin
    if (cmd.take_beam) begin
      idx_reg <= in_index;
      num_reg <= NUM_W'(in_index) * NUM_W'(rays_m1);
      err_reg <= ({1'b0, in_index} >= beams_eff);
    end
    if (cmd.div_load_idx) begin
      div_p  <= num_reg[NUM_W-1:IDX_W];
      div_lo <= {num_reg[IDX_W-1:0], {(RANGE_W-IDX_W){1'b0}}};
    end else if (cmd.div_load_acc) begin
      div_p  <= acc[ACC_W-1:RANGE_W];
      div_lo <= acc[RANGE_W-1:0];
    end else if (cmd.div_step) begin
      div_p  <= s2[IDX_W-1:0];
      div_lo <= {div_lo[RANGE_W-3:0], s1[IDX_W], s2[IDX_W]};
    end
    if (cmd.cap_quot) begin
      ja_reg  <= div_lo[RAY_AW-1:0];
      jb_reg  <= jb_val;
      rem_reg <= div_p;
    end
    if (cmd.cap_ra) begin
      ra       <= rd_range_clip;
      ra_retro <= rd_data[RANGE_W];
    end
    if (cmd.cap_rb) begin
      rb       <= rd_range_clip;
      rb_retro <= rd_data[RANGE_W];
      prod_a   <= ACC_W'(den - rem_reg) * ACC_W'(ra);
    end
    if (cmd.cap_close) begin
      close_reg <= sts.close;
    end
  end

  // Final range: quotient or minimum, plus offset, saturated.
  assign r_sel = close_reg ? div_lo : ((ra < rb) ? ra : rb);
  assign r_sum = {1'b0, r_sel} + {1'b0, range_offset};
  assign r_sat = r_sum[RANGE_W] ? {RANGE_W{1'b1}} : r_sum[RANGE_W-1:0];

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_index <= idx_reg;
      out_error <= err_reg;
      if (err_reg) begin
        out_slot  <= '0;
        out_range <= '0;
        out_int   <= 1'b0;
      end else begin
        out_slot  <= den - idx_reg;
        out_range <= r_sat;
        out_int   <= ra_retro | rb_retro;
      end
    end
  end

  assign out_tdata = {{(OUT_TDATA_W-2*IDX_W-RANGE_W-1){1'b0}},
                      out_int, out_range, out_slot, out_index};

  // The first division starts with a partial remainder below the divisor.
  a_div_start_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_load_idx |=> (div_p < den))
    else $error("division started with remainder not below divisor");

  // The lower neighbor always lies inside the ray count.
  a_ja_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.cap_quot |-> (ja_ext < rays_eff))
    else $error("lower neighbor beyond ray count");

  // The upper neighbor is the lower neighbor or the ray right after it.
  a_jb_follows_ja: assert property (@(posedge clk) disable iff (rst)
    cmd.cap_rb |-> ((jb_reg == ja_reg) || (jb_reg == ja_reg + RAY_AW'(1))))
    else $error("upper neighbor not next to lower neighbor");

endmodule

FILE: rtl/scan_ray_resampler_unit.sv
// Scan ray resampler.
// Input stream (s_axis): s_axis_tuser selects the item kind. A load item writes
// one ray's range and retro flag into the ray store and gives no result. A
// compute item asks for one output beam and gives exactly one result.
// Output stream (m_axis): one result per compute item; m_axis_tuser flags a
// beam index not below the beam count, with range slot, range and intensity zero.
// Configuration port: cfg_index selects a register, cfg_data carries the value;
// it is always ready and must only be written while the block is idle.
// A load is done in the idle state. A compute item interpolates the two
// neighbors when they are close, takes the minimum otherwise, and on an index
// error skips the divider and the reads. It uses the shared restoring divider, two
// quotient bits per cycle: 5 steps for the neighbor index, 8 steps for the
// weighted range when interpolating, plus two reads of the single-read-port ray store.
// The result sits in an output register; while it waits the block already
// works on the next item and stalls only if a second result would overwrite it.
// Reset restores the register defaults and empties the output; the ray store
// is not cleared and entries must be loaded before they are used.
module scan_ray_resampler_unit import srr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // item_index, ray_range_mm, ray_retro, zero pad
  input  logic                   s_axis_tuser,  // func
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // beam_index, range_slot, beam_range_mm,
                                                // beam_intensity, zero pad
  output logic                   m_axis_tuser,  // index_error
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  srr_cmd_t cmd;
  srr_sts_t sts;

  // Register writes are taken in every cycle.
  assign cfg_ready = 1'b1;

  srr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_func  (s_axis_tuser),
    .s_ready (s_axis_tready),
    .m_ready (m_axis_tready),
    .m_valid (m_axis_tvalid),
    .sts     (sts),
    .cmd     (cmd)
  );

  srr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_index  (s_axis_tdata[IDX_W-1:0]),
    .in_range  (s_axis_tdata[IDX_W+RANGE_W-1:IDX_W]),
    .in_retro  (s_axis_tdata[IDX_W+RANGE_W]),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (m_axis_tdata),
    .out_error (m_axis_tuser)
  );

endmodule

FILE: tb/sv/tb_scan_ray_resampler_unit.sv
module tb_scan_ray_resampler_unit import srr_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // Unused register slot; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  // Settle time that covers any work still in flight.
  localparam int SETTLE_CYCLES = 40;
  localparam int TARGET_ITEMS   = 2000;
  localparam int CALM_ITEMS     = 300;
  localparam int BEAMS_PER_SCAN = 150;
  // Rays reloaded with a fresh profile at the start of every scan.
  localparam int FRESH_RAYS     = 32;

  // One input item and one result, field by field.
  typedef struct packed {
    logic               func;
    logic [IDX_W-1:0]   index;
    logic [RANGE_W-1:0] range_mm;
    logic               retro;
  } ray_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   beam_index;
    logic [IDX_W-1:0]   range_slot;
    logic [RANGE_W-1:0] range_mm;
    logic               intensity;
    logic               index_error;
  } beam_t;

  // Scoreboard: keeps its own copy of the ray store and registers and
  // predicts each resampled beam from it.
  class resampler_scoreboard;
    logic [RANGE_W-1:0] range_mem [RAY_DEPTH];
    logic               retro_mem [RAY_DEPTH];
    logic [CNT_W-1:0]   ray_total;
    logic [CNT_W-1:0]   beam_total;
    logic [RANGE_W-1:0] ceil_mm;
    logic [RANGE_W-1:0] offset_mm;
    logic [RANGE_W-1:0] close_mm;
    beam_t              pending_beams [$];
    int errors, loads, computes, index_errors, interpolated, min_taken, saturated;
    int beams_seen;

    function new();
      ray_total  = RST_RAY_TOTAL;
      beam_total = RST_BEAM_TOTAL;
      ceil_mm    = RST_RANGE_CEIL;
      offset_mm  = RST_RANGE_OFFSET;
      close_mm   = RST_CLOSE_LIMIT;
    endfunction

    function int unsigned eff_count(logic [CNT_W-1:0] v, int unsigned hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned rays_eff();
      return eff_count(ray_total, RAY_DEPTH);
    endfunction

    function int unsigned beams_eff();
      return eff_count(beam_total, BEAM_LIMIT);
    endfunction

    function int pending();
      return pending_beams.size();
    endfunction

    function void note_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_RAY_TOTAL:    ray_total  = data[CNT_W-1:0];
        REG_BEAM_TOTAL:   beam_total = data[CNT_W-1:0];
        REG_RANGE_CEIL:   ceil_mm    = data[RANGE_W-1:0];
        REG_RANGE_OFFSET: offset_mm  = data[RANGE_W-1:0];
        REG_CLOSE_LIMIT:  close_mm   = data[RANGE_W-1:0];
        default: ;
      endcase
    endfunction

    // A load updates the store; a compute queues the expected beam.
    function void note_item(ray_item_t it);
      int unsigned rays, beams, den, num, ja, jb, rem, ra, rb, r, diff;
      longint unsigned acc;
      beam_t want;
      if (it.func == FUNC_LOAD) begin
        range_mem[it.index] = it.range_mm;
        retro_mem[it.index] = it.retro;
        loads++;
        return;
      end
      computes++;
      rays  = rays_eff();
      beams = beams_eff();
      want = '0;
      want.beam_index = it.index;
      if (32'(it.index) >= beams) begin
        want.index_error = 1'b1;
        index_errors++;
        pending_beams.push_back(want);
        return;
      end
      // Neighbor rays and the exact remainder weight.
      den = beams - 1;
      num = 32'(it.index) * (rays - 1);
      ja  = num / den;
      rem = num % den;
      jb  = (ja + 1 < rays) ? ja + 1 : rays - 1;
      ra  = range_mem[ja];
      rb  = range_mem[jb];
      if (ra > ceil_mm) ra = ceil_mm;
      if (rb > ceil_mm) rb = ceil_mm;
      diff = (ra > rb) ? ra - rb : rb - ra;
      if (diff < close_mm) begin
        acc = longint'(den - rem) * ra + longint'(rem) * rb;
        r = int'(acc / den);
        interpolated++;
      end else begin
        r = (ra < rb) ? ra : rb;
        min_taken++;
      end
      r = r + offset_mm;
      if (r > 32'hFFFF) begin
        r = 32'hFFFF;
        saturated++;
      end
      want.range_slot = IDX_W'(den - 32'(it.index));
      want.range_mm   = RANGE_W'(r);
      want.intensity  = retro_mem[ja] | retro_mem[jb];
      pending_beams.push_back(want);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // Compare one transfer on the result stream with the oldest prediction.
    task check_beam(beam_t got);
      beam_t want;
      beams_seen++;
      if (pending_beams.size() == 0) begin
        report($sformatf("unexpected beam %0d with nothing outstanding", got.beam_index));
        return;
      end
      want = pending_beams.pop_front();
      if (got.beam_index !== want.beam_index)
        report($sformatf("beam_index got %0d want %0d", got.beam_index, want.beam_index));
      if (got.range_slot !== want.range_slot)
        report($sformatf("beam %0d range_slot got %0d want %0d",
                         want.beam_index, got.range_slot, want.range_slot));
      if (got.range_mm !== want.range_mm)
        report($sformatf("beam %0d range got %0d want %0d",
                         want.beam_index, got.range_mm, want.range_mm));
      if (got.intensity !== want.intensity)
        report($sformatf("beam %0d intensity got %b want %b",
                         want.beam_index, got.intensity, want.intensity));
      if (got.index_error !== want.index_error)
        report($sformatf("beam %0d index_error got %b want %b",
                         want.beam_index, got.index_error, want.index_error));
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // item_index, ray_range_mm, ray_retro, zero pad
  logic                   s_axis_tuser;   // func
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // beam_index, range_slot, beam_range_mm,
                                          // beam_intensity, zero pad
  logic                   m_axis_tuser;   // index_error
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  resampler_scoreboard sb = new();
  logic      gaps_on;
  ray_item_t seen_item;
  beam_t     seen_beam;
  int        scans;
  // Rays 0 up to filled-1 have all been loaded at least once.
  int unsigned filled;

  scan_ray_resampler_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Clock with a 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Observe every transfer at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.note_reg(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready) begin
        seen_item.func     = s_axis_tuser;
        seen_item.index    = s_axis_tdata[0 +: IDX_W];
        seen_item.range_mm = s_axis_tdata[IDX_W +: RANGE_W];
        seen_item.retro    = s_axis_tdata[IDX_W + RANGE_W];
        sb.note_item(seen_item);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen_beam.beam_index  = m_axis_tdata[0 +: IDX_W];
        seen_beam.range_slot  = m_axis_tdata[IDX_W +: IDX_W];
        seen_beam.range_mm    = m_axis_tdata[2 * IDX_W +: RANGE_W];
        seen_beam.intensity   = m_axis_tdata[2 * IDX_W + RANGE_W];
        seen_beam.index_error = m_axis_tuser;
        sb.check_beam(seen_beam);
      end
    end
  end

  // Result side back-pressure in random bursts.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(0, 16)) @(negedge clk);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("Timeout with %0d beams outstanding", sb.pending());
    $display("CHECK FAILED");
    $finish;
  end

  // Present one item and hold it until the transfer happens.
  task automatic send_item(ray_item_t it);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = it.func;
    s_axis_tdata  = IN_TDATA_W'({it.retro, it.range_mm, it.index});
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic load_ray(int unsigned idx, int unsigned range_mm, logic retro);
    ray_item_t it;
    it.func     = FUNC_LOAD;
    it.index    = IDX_W'(idx);
    it.range_mm = RANGE_W'(range_mm);
    it.retro    = retro;
    send_item(it);
  endtask

  task automatic request_beam(int unsigned idx);
    ray_item_t it;
    it.func     = FUNC_COMPUTE;
    it.index    = IDX_W'(idx);
    it.range_mm = RANGE_W'($urandom);
    it.retro    = 1'($urandom);
    send_item(it);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Let every outstanding beam come back, then let the block settle.
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(int unsigned rays_w, int unsigned beams_w, int unsigned ceil,
                            int unsigned offset, int unsigned close);
    cfg_write(REG_RAY_TOTAL,    CFG_DATA_W'(rays_w));
    cfg_write(REG_BEAM_TOTAL,   CFG_DATA_W'(beams_w));
    cfg_write(REG_RANGE_CEIL,   CFG_DATA_W'(ceil));
    cfg_write(REG_RANGE_OFFSET, CFG_DATA_W'(offset));
    cfg_write(REG_CLOSE_LIMIT,  CFG_DATA_W'(close));
  endtask

  // Load n rays starting at first with a scan-like profile: mostly a smooth
  // walk so that neighbors interpolate, with jumps, zero returns and
  // max-range spikes.
  task automatic load_scan(int unsigned first, int unsigned n);
    int cur;
    int step;
    int unsigned val;
    int sel;
    cur  = $urandom_range(0, 65535);
    sel  = $urandom_range(0, 2);
    step = (sel == 0) ? 3 : (sel == 1) ? 60 : 600;
    for (int unsigned j = first; j < first + n; j++) begin
      case ($urandom_range(0, 15))
        0: begin
          cur = $urandom_range(0, 65535);
          val = cur;
        end
        1: val = 16'hFFFF;
        2: val = 0;
        default: begin
          cur = cur + int'($urandom_range(0, 2 * step)) - step;
          if (cur < 0) cur = 0;
          if (cur > 65535) cur = 65535;
          val = cur;
        end
      endcase
      load_ray(j, val, $urandom_range(0, 7) == 0);
    end
  endtask

  // Beam requests: a sweep or random indexes, some out of range, with the
  // odd ray reload mixed in.
  task automatic run_beams(int count);
    int unsigned beams;
    logic sweep;
    int unsigned idx;
    beams = sb.beams_eff();
    sweep = $urandom_range(0, 1);
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 19))
        0: load_ray($urandom_range(0, RAY_DEPTH - 1), $urandom_range(0, 65535),
                    $urandom_range(0, 1));
        1: begin
          idx = (beams < BEAM_LIMIT) ? $urandom_range(beams, BEAM_LIMIT - 1)
                                     : $urandom_range(0, beams - 1);
          request_beam(idx);
        end
        default: begin
          idx = sweep ? k % beams : $urandom_range(0, beams - 1);
          request_beam(idx);
        end
      endcase
    end
  endtask

  // Register draws that lean toward the extremes.
  function automatic int unsigned pick_count();
    int unsigned v;
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, 1);
      1: v = $urandom_range(BEAM_LIMIT + 1, 2047);
      2: v = 1024;
      default: v = $urandom_range(2, 400);
    endcase
    if ($urandom_range(0, 3) == 0) v = v | ($urandom_range(1, 31) << CNT_W);
    return v;
  endfunction

  function automatic int unsigned pick_range(int unsigned typical);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 65535;
      2: return $urandom_range(0, 65535);
      default: return $urandom_range(0, typical);
    endcase
  endfunction

  initial begin
    int phase;
    int unsigned ray_count;
    int unsigned fresh;
    rst           = 1'b1;
    gaps_on       = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_LOAD;
    cfg_valid     = 1'b0;
    cfg_index     = REG_RAY_TOTAL;
    cfg_data      = '0;
    scans         = 0;
    filled        = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fill every ray the reset ray count can reach so no request reads an
    // unloaded ray.
    load_scan(0, RST_RAY_TOTAL);
    filled = RST_RAY_TOTAL;

    // Directed cases under the reset register values (181 rays, 181 beams).
    load_ray(0, 16'hFFFF, 1'b1);     // above the ceiling, clamps to 8000
    load_ray(1, 7901, 1'b0);         // just inside the interpolation window
    request_beam(0);
    load_ray(2, 7801, 1'b0);         // difference equal to the limit
    request_beam(1);
    load_ray(179, 0, 1'b0);
    load_ray(180, 0, 1'b1);
    request_beam(180);               // last beam, both neighbors are the last ray
    request_beam(179);
    request_beam(181);               // first index past the beam count
    request_beam(1023);              // largest index
    load_ray(1023, 16'h5555, 1'b1);
    load_ray(512, 16'hAAAA, 1'b0);
    request_beam(90);
    request_beam(2);
    wait_idle();
    cfg_write(REG_UNUSED, 16'hFFFF);

    // Scans under changing register settings.
    phase = 0;
    while (sb.loads + sb.computes < TARGET_ITEMS) begin
      gaps_on = (sb.loads + sb.computes < TARGET_ITEMS - CALM_ITEMS) &&
                ($urandom_range(0, 3) != 0);
      case (phase)
        0: set_config(16'hF801, 2, 65535, 0, 65535);
        1: set_config(1024, 1024, 8000, 0, 100);
        2: set_config(0, 2047, 65535, 65535, 0);
        3: set_config(2047, 0, 0, 12345, 0);
        4: set_config(360, 181, 30000, 1000, 300);
        5: set_config(181, 360, 65535, 40000, 1000);
        default: set_config(pick_count(), pick_count(), pick_range(20000),
                            pick_range(2000), pick_range(500));
      endcase
      // Load rays the new ray count reaches for the first time, then give a
      // random window of the scan a fresh profile.
      ray_count = sb.rays_eff();
      if (ray_count > filled) begin
        load_scan(filled, ray_count - filled);
        filled = ray_count;
      end
      fresh = (ray_count < FRESH_RAYS) ? ray_count : FRESH_RAYS;
      load_scan($urandom_range(0, ray_count - fresh), fresh);
      run_beams(BEAMS_PER_SCAN);
      wait_idle();
      phase++;
      scans++;
    end

    $display("Covered %0d scans, %0d ray loads, %0d beam requests (%0d out of range).",
             scans, sb.loads, sb.computes, sb.index_errors);
    $display("Beams interpolated %0d, minimum taken %0d, saturated %0d; mismatches %0d.",
             sb.interpolated, sb.min_taken, sb.saturated, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
